>>> sv/assert_macros.svh
// Assertion macros used by the checker module.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked through reset as well.
`define ASSERT_CLK_NR(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/u8btc_pkg.sv
// Shared types and constants for the bounded UTF-8 text checker.
// No dependencies.
package u8btc_pkg;

  localparam int CountBits = 10;
  localparam int MaxCpW    = 10;
  localparam int BoundW    = (CountBits > MaxCpW) ? CountBits : MaxCpW;
  localparam int AddrW     = 3;
  localparam int DataW     = 32;

  localparam logic [MaxCpW-1:0] MaxCpRst = 10'd256;

  // Byte classes
  localparam logic [7:0] AsciiMin  = 8'h20;
  localparam logic [7:0] AsciiDel  = 8'h7F;
  localparam logic [7:0] Lead2Min  = 8'hC2;
  localparam logic [7:0] Lead2Max  = 8'hDF;
  localparam logic [7:0] Lead3Min  = 8'hE0;
  localparam logic [7:0] Lead3Max  = 8'hEF;
  localparam logic [7:0] Lead4Min  = 8'hF0;
  localparam logic [7:0] Lead4Max  = 8'hF4;
  localparam logic [7:0] ContMin   = 8'h80;
  localparam logic [7:0] ContMax   = 8'hBF;
  localparam logic [7:0] LeadE0    = 8'hE0;
  localparam logic [7:0] LeadED    = 8'hED;
  localparam logic [7:0] LeadF0    = 8'hF0;
  localparam logic [7:0] LeadF4    = 8'hF4;
  localparam logic [7:0] E0ContMin = 8'hA0;
  localparam logic [7:0] EDContMax = 8'h9F;
  localparam logic [7:0] F0ContMin = 8'h90;
  localparam logic [7:0] F4ContMax = 8'h8F;

  typedef enum logic [0:0] {
    RegMaxCp = 1'b0
  } u8btc_reg_t;

  typedef enum logic [1:0] {
    VerdictChecking = 2'd0,
    VerdictAccept   = 2'd1,
    VerdictReject   = 2'd2
  } u8btc_verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_text;
  } u8btc_in_t;

  typedef struct packed {
    u8btc_verdict_t verdict;
    logic           final_res;
  } u8btc_out_t;

  // Input register contents handed to the checking stage.
  typedef struct packed {
    logic      valid;
    u8btc_in_t item;
  } u8btc_stage_t;

endpackage

>>> sv/u8btc_cfg.sv
// Configuration register file: the code point bound behind an APB-style port.
// Depends on u8btc_pkg.
module u8btc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [u8btc_pkg::AddrW-1:0]   paddr,
  input  logic [u8btc_pkg::DataW-1:0]   pwdata,
  output logic [u8btc_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  output logic [u8btc_pkg::MaxCpW-1:0]  max_cp
);
  import u8btc_pkg::*;

  logic [MaxCpW-1:0] max_cp_r;
  logic [MaxCpW-1:0] max_cp_nxt;
  logic              sel_max;
  logic              wr_en;

  assign sel_max = (paddr[AddrW-1:2] == RegMaxCp);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    max_cp_nxt = max_cp_r;
    if (wr_en && sel_max) begin
      max_cp_nxt = pwdata[MaxCpW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cp_r <= MaxCpRst;
    end else begin
      max_cp_r <= max_cp_nxt;
    end
  end

  assign prdata = sel_max ? DataW'(max_cp_r) : '0;
  assign max_cp = max_cp_r;

endmodule

>>> sv/u8btc_in_reg.sv
// Input register stage: captures one byte beat and holds it until the
// checking stage takes it. Depends on u8btc_pkg.
module u8btc_in_reg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  u8btc_pkg::u8btc_in_t    in_data,
  input  logic                    adv,
  output u8btc_pkg::u8btc_stage_t stage
);
  import u8btc_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  u8btc_in_t item_r;
  logic      load;

  assign in_stall = valid_r && !adv;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

>>> sv/u8btc_core.sv
// Checking stage: per-text UTF-8 decoder state, code point counter and
// the result register. Depends on u8btc_pkg.
module u8btc_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  u8btc_pkg::u8btc_stage_t       stage,
  input  logic [u8btc_pkg::MaxCpW-1:0]  max_cp,
  output logic                          adv,
  output logic                          out_valid,
  input  logic                          out_stall,
  output u8btc_pkg::u8btc_out_t         out_data
);
  import u8btc_pkg::*;

  logic [1:0]           pend_r, pend_nxt;
  logic [7:0]           lead_r, lead_nxt;
  logic                 first_r, first_nxt;
  logic [CountBits-1:0] count_r, count_nxt;
  logic                 seen_r, seen_nxt;
  logic                 rej_r, rej_nxt;
  logic                 out_valid_r;
  u8btc_out_t           out_data_r;
  u8btc_out_t           res;

  logic [BoundW-1:0] cap_ext;
  logic [BoundW-1:0] max_ext;
  logic [BoundW-1:0] bound;
  logic              at_bound;
  logic [7:0]        b;
  logic              is_cont;
  logic              bad_first;
  logic              complete;
  logic [1:0]        pend_dec;
  logic              upd;

  assign adv = !out_valid_r || !out_stall;
  assign upd = stage.valid && adv;
  assign b   = stage.item.data_byte;

  // Bound is clipped to what the counter can hold.
  assign cap_ext  = BoundW'((32'd1 << CountBits) - 32'd1);
  assign max_ext  = BoundW'(max_cp);
  assign bound    = (max_ext < cap_ext) ? max_ext : cap_ext;
  assign at_bound = (BoundW'(count_r) >= bound);

  assign is_cont   = (b >= ContMin) && (b <= ContMax);
  assign bad_first = (lead_r == LeadE0 && b < E0ContMin) ||
                     (lead_r == LeadED && b > EDContMax) ||
                     (lead_r == LeadF0 && b < F0ContMin) ||
                     (lead_r == LeadF4 && b > F4ContMax);
  assign pend_dec  = pend_r - 2'd1;

  always_comb begin
    pend_nxt  = pend_r;
    lead_nxt  = lead_r;
    first_nxt = first_r;
    count_nxt = count_r;
    seen_nxt  = seen_r;
    rej_nxt   = rej_r;
    complete  = 1'b0;
    res.verdict   = VerdictChecking;
    res.final_res = stage.item.end_of_text;

    if (stage.item.byte_present) begin
      seen_nxt = 1'b1;
      if (!rej_r) begin
        if (pend_r == 2'd0) begin
          if (b <= AsciiDel) begin
            if (b < AsciiMin || b == AsciiDel) begin
              rej_nxt = 1'b1;
            end else begin
              complete = 1'b1;
            end
          end else if (b >= Lead2Min && b <= Lead2Max) begin
            pend_nxt  = 2'd1;
            lead_nxt  = b;
            first_nxt = 1'b1;
          end else if (b >= Lead3Min && b <= Lead3Max) begin
            pend_nxt  = 2'd2;
            lead_nxt  = b;
            first_nxt = 1'b1;
          end else if (b >= Lead4Min && b <= Lead4Max) begin
            pend_nxt  = 2'd3;
            lead_nxt  = b;
            first_nxt = 1'b1;
          end else begin
            rej_nxt = 1'b1;
          end
        end else if (!is_cont || (first_r && bad_first)) begin
          rej_nxt = 1'b1;
        end else begin
          first_nxt = 1'b0;
          pend_nxt  = pend_dec;
          complete  = (pend_dec == 2'd0);
        end
      end
    end

    if (complete) begin
      if (at_bound) begin
        rej_nxt = 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end

    if (stage.item.end_of_text) begin
      if (rej_nxt || !seen_nxt || pend_nxt != 2'd0) begin
        res.verdict = VerdictReject;
      end else begin
        res.verdict = VerdictAccept;
      end
      pend_nxt  = 2'd0;
      lead_nxt  = 8'd0;
      first_nxt = 1'b0;
      count_nxt = '0;
      seen_nxt  = 1'b0;
      rej_nxt   = 1'b0;
    end else if (rej_nxt) begin
      res.verdict = VerdictReject;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 2'd0;
      lead_r      <= 8'd0;
      first_r     <= 1'b0;
      count_r     <= '0;
      seen_r      <= 1'b0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (upd) begin
        pend_r  <= pend_nxt;
        lead_r  <= lead_nxt;
        first_r <= first_nxt;
        count_r <= count_nxt;
        seen_r  <= seen_nxt;
        rej_r   <= rej_nxt;
      end
      if (adv) begin
        out_valid_r <= stage.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/utf8_bounded_text_checker.sv
// Bounded strict UTF-8 text checker, one byte beat per clock while neither stage is stalled.
// A verdict is presented from the result register, which the input register feeds once
// the checking stage advances. Throughput: one beat per cycle while out_stall is low;
// decode and counter update in the checking stage are combinational.
// Reset (rst_n low, synchronous): both stages empty, text state cleared, bound = 256.
module utf8_bounded_text_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  u8btc_pkg::u8btc_in_t          in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output u8btc_pkg::u8btc_out_t         out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [u8btc_pkg::AddrW-1:0]   paddr,
  input  logic [u8btc_pkg::DataW-1:0]   pwdata,
  output logic [u8btc_pkg::DataW-1:0]   prdata,
  output logic                          pready
);
  import u8btc_pkg::*;

  u8btc_stage_t      stage;
  logic              adv;
  logic [MaxCpW-1:0] max_cp;

  u8btc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_cp  (max_cp)
  );

  u8btc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .stage    (stage)
  );

  u8btc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .max_cp    (max_cp),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> sv/u8btc_checker.sv
// Port-level checks for the bounded UTF-8 text checker, bound to the top level.
// Depends on u8btc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8btc_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input u8btc_pkg::u8btc_out_t out_data
);
  import u8btc_pkg::*;

  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")

  // A rejection inside a text carries to every later beat of that text.
  `ASSERT_CLK(a_reject_sticky, out_valid && !out_stall && out_data.verdict == VerdictReject && !out_data.final_res |=> !out_valid || out_data.verdict == VerdictReject, "rejection not sticky")

  `ASSERT_CLK(a_verdict_code, out_valid |-> (out_data.final_res && out_data.verdict != VerdictChecking) || (!out_data.final_res && out_data.verdict != VerdictAccept), "verdict does not fit end flag")

  `ASSERT_CLK_NR(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind utf8_bounded_text_checker u8btc_checker u_u8btc_checker (.*);
